// ===== hw/rtl/btf_pkg.sv =====
// Shared types, constants and saturation helpers for the brush tire force step.
`default_nettype none
package btf_pkg;

   localparam int CsrIdxW = 3;
   localparam int CfgW    = 31;

   // Register indexes of the configuration port
   localparam logic [CsrIdxW-1:0] CSR_RADIUS = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_MASS   = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_LSC    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_ASC    = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_PF     = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_RC     = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_DT     = 3'd6;

   localparam logic [CfgW-1:0] RST_RADIUS = 31'd21627;
   localparam logic [CfgW-1:0] RST_MASS   = 31'd1310720;
   localparam logic [CfgW-1:0] RST_LSC    = 31'd65536;
   localparam logic [CfgW-1:0] RST_ASC    = 31'd65536;
   localparam logic [CfgW-1:0] RST_PF     = 31'd65536;
   localparam logic [CfgW-1:0] RST_RC     = 31'd983;
   localparam logic [CfgW-1:0] RST_DT     = 31'd1092;

   localparam logic [31:0] SLIP_LOCK_LIMIT = 32'd11469;
   localparam logic [30:0] SCREECH_SPEED   = 31'd327680;
   localparam logic [34:0] GAIN_FULL       = 35'd65536;
   localparam logic [31:0] TANA_FLOOR      = 32'd32768;
   localparam logic [63:0] Q_HALF          = 64'd32768;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_R2, OP_INER, OP_INSET, OP_WC, OP_LS, OP_AS, OP_FMAX,
      OP_ROLL, OP_MB, OP_SLIP, OP_TANA, OP_FX0M, OP_FY0M, OP_G1, OP_G2, OP_SQ,
      OP_CMP, OP_DFX, OP_DFY, OP_FY, OP_NET, OP_NET2, OP_AIR, OP_ALPHA, OP_WNEW,
      OP_OUT
   } op_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_R2, ST_INER, ST_INSET, ST_WC, ST_LS, ST_AS, ST_FMAX, ST_ROLL,
      ST_MB, ST_SLIP, ST_SLIP_W, ST_TANA, ST_TANA_W, ST_FX0M, ST_FY0M, ST_G1,
      ST_G2, ST_SQ, ST_SQ_W, ST_CMP, ST_BR, ST_DFX, ST_DFX_W, ST_DFY, ST_DFY_W,
      ST_FY, ST_NET, ST_NET2, ST_AIR, ST_ALPHA_W, ST_ALPHA, ST_WNEW, ST_DONE
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
      logic sqrt_busy;
      logic contact;
      logic sliding;
   } status_type;

   // Apply a sign to a magnitude and saturate to 32 bits signed
   function automatic logic [31:0] sat_sign(input logic neg, input logic [63:0] m);
      logic [31:0] r;
      if (m >= 64'h8000_0000) begin
         r = neg ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
         r = neg ? 32'(-m[31:0]) : m[31:0];
      end
      return r;
   endfunction

   // Saturate a wide signed sum to 32 bits signed
   function automatic logic [31:0] sat32(input logic signed [34:0] v);
      logic [31:0] r;
      if (v > 35'sh0_7fff_ffff) begin
         r = 32'h7fff_ffff;
      end else if (v < -35'sh0_8000_0000) begin
         r = 32'h8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [31:0] mag32(input logic signed [31:0] v);
      return v[31] ? 32'(-v) : v;
   endfunction

   // Rounded quotient numerator: (|a| << 16) + |b| / 2
   function automatic logic [63:0] qdiv_num(input logic [32:0] a, input logic [31:0] b);
      return {15'd0, a, 16'd0} + {33'd0, b[31:1]};
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/btf_div.sv =====
// Restoring divider, one quotient bit per cycle, signed saturating result.
`default_nettype none
module btf_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] num,
   input  wire logic [31:0] den,
   input  wire logic        neg,
   output logic             busy,
   output logic [31:0]      result
);
   import btf_pkg::*;

   logic [63:0] num_ff, num_in, q_ff, q_in;
   logic [31:0] rem_ff, rem_in, den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, neg_ff, neg_in, zero_ff, zero_in;
   logic [32:0] rem_sh;
   logic        fits;

   assign rem_sh = {rem_ff, num_ff[63]};
   assign fits   = rem_sh >= {1'b0, den_ff};

   // Load on start, else shift one bit a cycle while busy
   always_comb begin
      num_in = num_ff; q_in = q_ff; rem_in = rem_ff; den_in = den_ff;
      cnt_in = cnt_ff; busy_in = busy_ff; neg_in = neg_ff; zero_in = zero_ff;
      if (start) begin
         num_in = num; q_in = '0; rem_in = '0; den_in = den; cnt_in = '0;
         busy_in = 1'b1; neg_in = neg; zero_in = (den == '0);
      end else if (busy_ff) begin
         num_in = {num_ff[62:0], 1'b0};
         q_in   = {q_ff[62:0], fits};
         rem_in = fits ? 32'(rem_sh - {1'b0, den_ff}) : rem_sh[31:0];
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd63) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      num_ff <= num_in; q_ff <= q_in; rem_ff <= rem_in; den_ff <= den_in;
      cnt_ff <= cnt_in; neg_ff <= neg_in; zero_ff <= zero_in;
   end

   assign busy   = busy_ff;
   assign result = zero_ff ? 32'd0 : sat_sign(neg_ff, q_ff);

endmodule
`default_nettype wire

// ===== hw/rtl/btf_sqrt.sv =====
// Integer square root of a 64-bit value, one result bit per cycle.
`default_nettype none
module btf_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] x,
   output logic             busy,
   output logic [31:0]      root
);
   import btf_pkg::*;

   logic [63:0] x_ff, x_in, res_ff, res_in, bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;

   // Load on start, else try one root bit
   always_comb begin
      x_in = x_ff; res_in = res_ff; bit_in = bit_ff; busy_in = busy_ff;
      if (start) begin
         x_in = x; res_in = '0; bit_in = 64'h4000_0000_0000_0000; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (x_ff >= trial) begin
            x_in   = x_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in  = bit_ff >> 2;
         busy_in = (bit_in != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      x_ff <= x_in; res_ff <= res_in; bit_ff <= bit_in;
   end

   assign busy = busy_ff;
   assign root = res_ff[31:0];

endmodule
`default_nettype wire

// ===== hw/rtl/btf_ctrl.sv =====
// Sequencer that steps the datapath through one tick and owns the handshakes.
`default_nettype none
module btf_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire btf_pkg::status_type status,
   output btf_pkg::cmd_type         cmd
);
   import btf_pkg::*;

   state_type state_ff, state_in;
   logic      valid_ff, valid_in;
   logic      out_free;

   assign out_free = !valid_ff || rsp_tready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_tvalid) state_in = ST_R2;
         ST_R2:      state_in = ST_INER;
         ST_INER:    state_in = ST_INSET;
         ST_INSET:   state_in = status.contact ? ST_WC : ST_AIR;
         ST_WC:      state_in = ST_LS;
         ST_LS:      state_in = ST_AS;
         ST_AS:      state_in = ST_FMAX;
         ST_FMAX:    state_in = ST_ROLL;
         ST_ROLL:    state_in = ST_MB;
         ST_MB:      state_in = ST_SLIP;
         ST_SLIP:    state_in = ST_SLIP_W;
         ST_SLIP_W:  if (!status.div_busy) state_in = ST_TANA;
         ST_TANA:    state_in = ST_TANA_W;
         ST_TANA_W:  if (!status.div_busy) state_in = ST_FX0M;
         ST_FX0M:    state_in = ST_FY0M;
         ST_FY0M:    state_in = ST_G1;
         ST_G1:      state_in = ST_G2;
         ST_G2:      state_in = ST_SQ;
         ST_SQ:      state_in = ST_SQ_W;
         ST_SQ_W:    if (!status.sqrt_busy) state_in = ST_CMP;
         ST_CMP:     state_in = ST_BR;
         ST_BR:      state_in = status.sliding ? ST_DFX : ST_NET;
         ST_DFX:     state_in = ST_DFX_W;
         ST_DFX_W:   if (!status.div_busy) state_in = ST_DFY;
         ST_DFY:     state_in = ST_DFY_W;
         ST_DFY_W:   if (!status.div_busy) state_in = ST_FY;
         ST_FY:      state_in = ST_NET;
         ST_NET:     state_in = ST_NET2;
         ST_NET2:    state_in = ST_ALPHA_W;
         ST_AIR:     state_in = ST_ALPHA_W;
         ST_ALPHA_W: if (!status.div_busy) state_in = ST_ALPHA;
         ST_ALPHA:   state_in = ST_WNEW;
         ST_WNEW:    state_in = ST_DONE;
         ST_DONE:    if (out_free) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // Outputs: at most one datapath command per state
   always_comb begin
      cmd.op = OP_NONE;
      unique case (state_ff)
         ST_IDLE:  if (req_tvalid) cmd.op = OP_LOAD;
         ST_R2:    cmd.op = OP_R2;
         ST_INER:  cmd.op = OP_INER;
         ST_INSET: cmd.op = OP_INSET;
         ST_WC:    cmd.op = OP_WC;
         ST_LS:    cmd.op = OP_LS;
         ST_AS:    cmd.op = OP_AS;
         ST_FMAX:  cmd.op = OP_FMAX;
         ST_ROLL:  cmd.op = OP_ROLL;
         ST_MB:    cmd.op = OP_MB;
         ST_SLIP:  cmd.op = OP_SLIP;
         ST_TANA:  cmd.op = OP_TANA;
         ST_FX0M:  cmd.op = OP_FX0M;
         ST_FY0M:  cmd.op = OP_FY0M;
         ST_G1:    cmd.op = OP_G1;
         ST_G2:    cmd.op = OP_G2;
         ST_SQ:    cmd.op = OP_SQ;
         ST_CMP:   cmd.op = OP_CMP;
         ST_DFX:   cmd.op = OP_DFX;
         ST_DFY:   cmd.op = OP_DFY;
         ST_FY:    cmd.op = OP_FY;
         ST_NET:   cmd.op = OP_NET;
         ST_NET2:  cmd.op = OP_NET2;
         ST_AIR:   cmd.op = OP_AIR;
         ST_ALPHA: cmd.op = OP_ALPHA;
         ST_WNEW:  cmd.op = OP_WNEW;
         ST_DONE:  if (out_free) cmd.op = OP_OUT;
         default:  cmd.op = OP_NONE;
      endcase
   end

   // Result valid: set when the result register is loaded, drop when taken
   always_comb begin
      valid_in = valid_ff;
      if (rsp_tready) valid_in = 1'b0;
      if (state_ff == ST_DONE && out_free) valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/btf_dp.sv =====
// Datapath: registers, shared multiplier, divider and root unit for one tick.
`default_nettype none
module btf_dp (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire btf_pkg::cmd_type           cmd,
   output btf_pkg::status_type             status,
   input  wire logic                       csr_we,
   input  wire logic [btf_pkg::CsrIdxW-1:0] csr_index,
   input  wire logic [btf_pkg::CfgW-1:0]   csr_wdata,
   input  wire logic                       in_contact,
   input  wire logic signed [31:0]         long_speed,
   input  wire logic signed [31:0]         lat_speed,
   input  wire logic [30:0]                ground_speed,
   input  wire logic [30:0]                normal_load,
   input  wire logic signed [31:0]         drive_torque,
   input  wire logic [30:0]                brake_torque,
   output logic signed [31:0]              long_force,
   output logic signed [31:0]              lat_force,
   output logic [30:0]                     rolling_force,
   output logic signed [31:0]              new_wheel_speed,
   output logic                            is_sliding,
   output logic                            is_locked,
   output logic [16:0]                     screech_gain
);
   import btf_pkg::*;

   // Configuration
   logic [CfgW-1:0] rad_ff, mass_ff, lsc_ff, asc_ff, pf_ff, rc_ff, dt_ff;
   // Item fields
   logic               contact_ff;
   logic signed [31:0] vx_ff, vy_ff, drv_ff;
   logic [30:0]        gs_ff, fz_ff, brk_ff, m5_ff;
   // Tick state
   logic signed [31:0] w_ff, wbase_ff;
   logic               lock_ff;
   // Working values
   logic signed [31:0] r2_ff, inertia_ff, wc_ff, ls_ff, as_ff, fmax_ff, roll_ff, mb_ff;
   logic signed [31:0] slip_ff, tana_ff, fx0_ff, fy0_ff, fx_ff, fy_ff;
   logic [63:0]        g2_ff, prod_ff;
   logic [30:0]        gamma_ff;
   logic               pneg_ff, sliding_ff;
   logic [16:0]        gain_ff;
   // Result register
   logic signed [31:0] o_fx_ff, o_fy_ff, o_w_ff;
   logic [30:0]        o_roll_ff;
   logic               o_slide_ff, o_lock_ff;
   logic [16:0]        o_gain_ff;

   // Shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic               mul_en;
   logic [31:0]        mag_a, mag_b;
   logic signed [31:0] q_val, q_neg;

   // Divider and root unit
   logic        dv_start, dv_neg, dv_busy, sq_start, sq_busy;
   logic [63:0] dv_num, sq_x;
   logic [31:0] dv_den, dv_res, sq_root;
   logic signed [31:0] d_val;

   // Helper terms
   logic signed [32:0] diff, bt;
   logic [32:0]        magd;
   logic [31:0]        avx, awc, slip_den, tana_den;
   logic [30:0]        gamma_c;
   logic signed [34:0] net_gnd, net_air, w_sum;
   logic signed [31:0] net_sat, air_sat;
   logic               brk_gt_mb, lock_set, lock_n;
   logic [34:0]        gv;
   logic [33:0]        m5_full;

   assign mag_a = mul_a[32] ? 32'(-mul_a) : mul_a[31:0];
   assign mag_b = mul_b[32] ? 32'(-mul_b) : mul_b[31:0];
   assign q_val = sat_sign(pneg_ff, (prod_ff + Q_HALF) >> 16);
   assign q_neg = (q_val == 32'sh8000_0000) ? 32'sh7fff_ffff : -q_val;
   assign d_val = dv_res;

   assign diff     = {vx_ff[31], vx_ff} - {wc_ff[31], wc_ff};
   assign magd     = diff[32] ? 33'(-diff) : diff;
   assign avx      = mag32(vx_ff);
   assign awc      = mag32(wc_ff);
   assign slip_den = (avx > awc) ? avx : awc;
   assign tana_den = (avx > TANA_FLOOR) ? avx : TANA_FLOOR;
   assign gamma_c  = (sq_root >= 32'h8000_0000) ? 31'h7fff_ffff : sq_root[30:0];
   assign m5_full  = {3'd0, mass_ff} * 34'd5;

   // Brake opposes spin, none on a still wheel
   assign bt = (brk_ff != '0 && w_ff != '0) ?
               (w_ff[31] ? $signed({2'b0, brk_ff}) : -$signed({2'b0, brk_ff})) : 33'sd0;
   assign net_gnd = {{3{drv_ff[31]}}, drv_ff} - {{3{q_val[31]}}, q_val} + {{2{bt[32]}}, bt};
   assign net_air = {{3{drv_ff[31]}}, drv_ff} + {{2{bt[32]}}, bt} - {{2{w_ff[31]}}, w_ff, 1'b0};
   assign net_sat = sat32(net_gnd);
   assign air_sat = sat32(net_air);
   assign w_sum   = {{3{wbase_ff[31]}}, wbase_ff} + {{3{q_val[31]}}, q_val};

   assign brk_gt_mb = {1'b0, brk_ff} > mb_ff;
   assign lock_set  = sliding_ff && brk_gt_mb && (mag32(slip_ff) > SLIP_LOCK_LIMIT);
   assign lock_n    = lock_set || lock_ff;
   assign gv        = (slip_ff > 0) ? 35'(slip_ff) : {1'b0, mag32(slip_ff), 2'b00};

   // Issue multiplies and unit starts for the current step
   always_comb begin
      mul_a = '0; mul_b = '0; mul_en = 1'b1;
      dv_start = 1'b0; dv_num = '0; dv_den = '0; dv_neg = 1'b0;
      sq_start = 1'b0; sq_x = g2_ff + prod_ff;
      case (cmd.op)
         OP_R2:    begin mul_a = {2'b0, rad_ff}; mul_b = {2'b0, rad_ff}; end
         OP_INER:  begin mul_a = {2'b0, m5_ff}; mul_b = {q_val[31], q_val}; end
         OP_WC:    begin mul_a = {w_ff[31], w_ff}; mul_b = {2'b0, rad_ff}; end
         OP_LS:    begin mul_a = {2'b0, lsc_ff}; mul_b = {2'b0, fz_ff}; end
         OP_AS:    begin mul_a = {2'b0, asc_ff}; mul_b = {2'b0, fz_ff}; end
         OP_FMAX:  begin mul_a = {2'b0, pf_ff}; mul_b = {2'b0, fz_ff}; end
         OP_ROLL:  begin mul_a = {2'b0, rc_ff}; mul_b = {2'b0, fz_ff}; end
         OP_MB:    begin mul_a = {fmax_ff[31], fmax_ff}; mul_b = {2'b0, rad_ff}; end
         OP_FX0M:  begin mul_a = {ls_ff[31], ls_ff}; mul_b = {slip_ff[31], slip_ff}; end
         OP_FY0M:  begin mul_a = {as_ff[31], as_ff}; mul_b = {tana_ff[31], tana_ff}; end
         OP_G1:    begin mul_a = {fx0_ff[31], fx0_ff}; mul_b = {fx0_ff[31], fx0_ff}; end
         OP_G2:    begin mul_a = {fy0_ff[31], fy0_ff}; mul_b = {fy0_ff[31], fy0_ff}; end
         OP_CMP:   begin mul_a = {fmax_ff[31], fmax_ff}; mul_b = {fx0_ff[31], fx0_ff}; end
         OP_NET:   begin mul_a = {fx_ff[31], fx_ff}; mul_b = {2'b0, rad_ff}; end
         OP_ALPHA: begin mul_a = {d_val[31], d_val}; mul_b = {2'b0, dt_ff}; end
         OP_SLIP: begin
            mul_en = 1'b0;
            dv_start = 1'b1; dv_num = qdiv_num(magd, slip_den);
            dv_den = slip_den; dv_neg = diff[32];
         end
         OP_TANA: begin
            mul_en = 1'b0;
            dv_start = 1'b1; dv_num = qdiv_num({1'b0, mag32(vy_ff)}, tana_den);
            dv_den = tana_den; dv_neg = vy_ff[31];
         end
         OP_SQ: begin
            mul_en = 1'b0; sq_start = 1'b1;
         end
         OP_DFX: begin
            mul_a = {fmax_ff[31], fmax_ff}; mul_b = {fy0_ff[31], fy0_ff};
            dv_start = 1'b1; dv_num = prod_ff + {34'd0, gamma_ff[30:1]};
            dv_den = {1'b0, gamma_ff}; dv_neg = fx0_ff[31];
         end
         OP_DFY: begin
            mul_en = 1'b0;
            dv_start = 1'b1; dv_num = prod_ff + {34'd0, gamma_ff[30:1]};
            dv_den = {1'b0, gamma_ff}; dv_neg = fy0_ff[31];
         end
         OP_NET2: begin
            mul_en = 1'b0;
            dv_start = 1'b1; dv_num = qdiv_num({1'b0, mag32(net_sat)}, inertia_ff);
            dv_den = inertia_ff; dv_neg = net_sat[31];
         end
         OP_AIR: begin
            mul_en = 1'b0;
            dv_start = 1'b1; dv_num = qdiv_num({1'b0, mag32(air_sat)}, inertia_ff);
            dv_den = inertia_ff; dv_neg = air_sat[31];
         end
         default: mul_en = 1'b0;
      endcase
   end

   // Configuration and tick state
   always_ff @(posedge clock) begin
      if (reset) begin
         rad_ff <= RST_RADIUS; mass_ff <= RST_MASS; lsc_ff <= RST_LSC;
         asc_ff <= RST_ASC; pf_ff <= RST_PF; rc_ff <= RST_RC; dt_ff <= RST_DT;
         w_ff <= '0; lock_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_RADIUS: rad_ff  <= csr_wdata;
               CSR_MASS:   mass_ff <= csr_wdata;
               CSR_LSC:    lsc_ff  <= csr_wdata;
               CSR_ASC:    asc_ff  <= csr_wdata;
               CSR_PF:     pf_ff   <= csr_wdata;
               CSR_RC:     rc_ff   <= csr_wdata;
               CSR_DT:     dt_ff   <= csr_wdata;
               default:    ;
            endcase
         end
         // Update lock before integration, release when brake is within reach or not sliding
         if (cmd.op == OP_NET2) begin
            lock_ff <= (!brk_gt_mb || !sliding_ff) ? 1'b0 : lock_n;
         end
         if (cmd.op == OP_WNEW) begin
            w_ff <= sat32(w_sum);
         end
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      if (mul_en) begin
         prod_ff <= 64'(mag_a * mag_b);
         pneg_ff <= mul_a[32] ^ mul_b[32];
      end
      case (cmd.op)
         OP_LOAD: begin
            contact_ff <= in_contact; vx_ff <= long_speed; vy_ff <= lat_speed;
            gs_ff <= ground_speed; fz_ff <= normal_load; drv_ff <= drive_torque;
            brk_ff <= brake_torque;
            m5_ff <= (m5_full > 34'h0_7fff_ffff) ? 31'h7fff_ffff : m5_full[30:0];
            fx_ff <= '0; fy_ff <= '0; roll_ff <= '0; gain_ff <= '0; sliding_ff <= 1'b0;
         end
         OP_INER:  r2_ff <= q_val;
         OP_INSET: inertia_ff <= (q_val == '0) ? 32'sd1 : q_val;
         OP_LS:    wc_ff <= q_val;
         OP_AS:    ls_ff <= q_val;
         OP_FMAX:  as_ff <= q_val;
         OP_ROLL:  fmax_ff <= q_val;
         OP_MB:    roll_ff <= q_val;
         OP_SLIP:  mb_ff <= q_val;
         OP_TANA:  slip_ff <= d_val;
         OP_FX0M:  tana_ff <= d_val;
         OP_FY0M:  fx0_ff <= q_neg;
         OP_G1:    fy0_ff <= q_neg;
         OP_G2:    g2_ff <= prod_ff;
         OP_CMP: begin
            // Inside the friction circle clamp each force to the peak
            gamma_ff   <= gamma_c;
            sliding_ff <= !($signed({1'b0, gamma_c}) < fmax_ff);
            fx_ff <= (fx0_ff > fmax_ff) ? fmax_ff : ((fx0_ff < -fmax_ff) ? -fmax_ff : fx0_ff);
            fy_ff <= (fy0_ff > fmax_ff) ? fmax_ff : ((fy0_ff < -fmax_ff) ? -fmax_ff : fy0_ff);
         end
         OP_DFY:   fx_ff <= d_val;
         OP_FY:    fy_ff <= d_val;
         OP_NET2: begin
            wbase_ff <= lock_n ? 32'sd0 : w_ff;
            if (sliding_ff && gs_ff > SCREECH_SPEED) begin
               gain_ff <= (gv > GAIN_FULL) ? 17'(GAIN_FULL) : gv[16:0];
            end
         end
         OP_AIR:   wbase_ff <= w_ff;
         OP_OUT: begin
            o_fx_ff <= fx_ff; o_fy_ff <= fy_ff; o_roll_ff <= roll_ff[30:0];
            o_w_ff <= w_ff; o_slide_ff <= sliding_ff; o_lock_ff <= lock_ff;
            o_gain_ff <= gain_ff;
         end
         default: ;
      endcase
   end

   btf_div u_div (
      .clock(clock), .reset(reset), .start(dv_start), .num(dv_num), .den(dv_den),
      .neg(dv_neg), .busy(dv_busy), .result(dv_res)
   );

   btf_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(sq_start), .x(sq_x), .busy(sq_busy),
      .root(sq_root)
   );

   assign status.div_busy  = dv_busy;
   assign status.sqrt_busy = sq_busy;
   assign status.contact   = contact_ff;
   assign status.sliding   = sliding_ff;

   assign long_force      = o_fx_ff;
   assign lat_force       = o_fy_ff;
   assign rolling_force   = o_roll_ff;
   assign new_wheel_speed = o_w_ff;
   assign is_sliding      = o_slide_ff;
   assign is_locked       = o_lock_ff;
   assign screech_gain    = o_gain_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/brush_tire_force_step.sv =====
// Top level of the brush tire force step: stream ports, sequencer and datapath.
// Up to five quotients go through the serial divider and one root through the root unit.
// One item at a time; a new item is taken while the last result waits.
// Reset (synchronous, active high) zeroes wheel speed and lock, loads default registers.
`default_nettype none
module brush_tire_force_step (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // in_contact, long_speed, lat_speed, ground_speed, normal_load, drive_torque,
   // brake_torque
   input  wire logic [191:0]                 req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // long_force, lat_force, rolling_force, new_wheel_speed, is_sliding, is_locked,
   // screech_gain
   output logic [151:0]                      rsp_tdata,
   input  wire logic                         csr_we,
   input  wire logic [btf_pkg::CsrIdxW-1:0]  csr_index,
   input  wire logic [btf_pkg::CfgW-1:0]     csr_wdata
);
   import btf_pkg::*;

   cmd_type            cmd;
   status_type         status;
   logic signed [31:0] long_force, lat_force, new_wheel_speed;
   logic [30:0]        rolling_force;
   logic               is_sliding, is_locked;
   logic [16:0]        screech_gain;

   btf_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .status(status), .cmd(cmd)
   );

   btf_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .in_contact(req_tdata[0]), .long_speed(req_tdata[32:1]),
      .lat_speed(req_tdata[64:33]), .ground_speed(req_tdata[95:65]),
      .normal_load(req_tdata[126:96]), .drive_torque(req_tdata[158:127]),
      .brake_torque(req_tdata[189:159]),
      .long_force(long_force), .lat_force(lat_force), .rolling_force(rolling_force),
      .new_wheel_speed(new_wheel_speed), .is_sliding(is_sliding), .is_locked(is_locked),
      .screech_gain(screech_gain)
   );

   // Pack result fields, lowest first
   assign rsp_tdata = {6'd0, screech_gain, is_locked, is_sliding, new_wheel_speed,
                       rolling_force, lat_force, long_force};

endmodule
`default_nettype wire

// ===== hw/rtl/btf_chk.sv =====
// Port checker for the brush tire force step, bound to the top level.
`default_nettype none
module btf_chk (
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [151:0] rsp_tdata
);
   // Hold a stalled result
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   // One item in work at a time
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item taken while busy");

   // Screech only while sliding
   a_gain_slide: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[145:129] != 17'd0) |-> rsp_tdata[127])
      else $error("screech without sliding");

endmodule

bind brush_tire_force_step btf_chk u_chk (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
);
`default_nettype wire
